### src/audio_ring_overrun_skip_reader_unit_macros.svh
// Assertion macros used by the checker file of the audio ring reader.
`ifndef AUDIO_RING_OVERRUN_SKIP_READER_UNIT_MACROS_SVH
`define AUDIO_RING_OVERRUN_SKIP_READER_UNIT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define AROSR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Property checked on every clock edge, reset included.
`define AROSR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

### src/arosr_pkg.sv
// ----------------------------------------------------------------------------
// arosr_pkg
// Shared constants, codes and helpers of the audio ring overrun-skip reader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arosr_pkg;

   localparam int DEF_CAPACITY_FRAMES = 1024;
   localparam int DEF_CHANNELS        = 2;
   localparam int DEF_MAX_READ_FRAMES = 32;
   localparam int QUEUE_DEPTH         = 4;

   localparam int SAMPLE_W    = 32;
   localparam int CURSOR_W    = 48;
   localparam int FRAMES_IN_W = 6;
   localparam int REQ_DATA_W  = 88;
   localparam int RSP_DATA_W  = 80;

   // Item kinds, as carried in the request tuser bit.
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // Width of one entry of the queue between the front and back parts.
   function automatic int entry_w(input int cap, input int chans, input int max_rd);
      return 1 + SAMPLE_W + $clog2(cap * chans) + 2 * $clog2(max_rd + 1) + CURSOR_W;
   endfunction

endpackage

`default_nettype wire

### src/arosr_ram.sv
// ----------------------------------------------------------------------------
// arosr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arosr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/arosr_front.sv
// ----------------------------------------------------------------------------
// arosr_front
// Accepts items, tracks the writer position and works out each read's plan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arosr_front #(
   parameter int CAPACITY_FRAMES = arosr_pkg::DEF_CAPACITY_FRAMES,
   parameter int CHANNELS        = arosr_pkg::DEF_CHANNELS,
   parameter int MAX_READ_FRAMES = arosr_pkg::DEF_MAX_READ_FRAMES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept_en,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic                               in_func,
   input  logic [arosr_pkg::SAMPLE_W-1:0]     in_sample,
   input  logic [arosr_pkg::CURSOR_W-1:0]     in_cursor,
   input  logic [arosr_pkg::FRAMES_IN_W-1:0]  in_frames,
   output logic                               push_valid,
   input  logic                               push_ready,
   output logic [arosr_pkg::entry_w(CAPACITY_FRAMES, CHANNELS, MAX_READ_FRAMES)-1:0]
                                              push_data
);
   import arosr_pkg::*;

   localparam int SW = $clog2(CAPACITY_FRAMES);
   localparam int AW = $clog2(CAPACITY_FRAMES * CHANNELS);
   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int RW = $clog2(MAX_READ_FRAMES + 1);
   localparam int VW = $clog2(CAPACITY_FRAMES + 1);
   localparam int MW = (VW > RW) ? VW : RW;

   localparam logic [SW-1:0]         LAST_SLOT = SW'(CAPACITY_FRAMES - 1);
   localparam logic [AW-1:0]         LAST_WORD = AW'(CAPACITY_FRAMES * CHANNELS - 1);
   localparam logic [CW-1:0]         LAST_CH   = CW'(CHANNELS - 1);
   localparam logic [CURSOR_W:0]     CAP_WIDE  = (CURSOR_W + 1)'(CAPACITY_FRAMES);
   localparam logic [CURSOR_W-1:0]   CAP_CUR   = CURSOR_W'(CAPACITY_FRAMES);
   localparam logic [VW-1:0]         CAP_V     = VW'(CAPACITY_FRAMES);
   localparam logic [VW:0]           CAP_VX    = (VW + 1)'(CAPACITY_FRAMES);
   localparam logic [FRAMES_IN_W:0]  MAX_REQ   = (FRAMES_IN_W + 1)'(MAX_READ_FRAMES);

   typedef struct packed {
      logic                kind;
      logic [SAMPLE_W-1:0] sample;
      logic [AW-1:0]       addr;
      logic [RW-1:0]       frames;
      logic [RW-1:0]       to_read;
      logic [CURSOR_W-1:0] cursor;
   } entry_type;

   // Writer position.
   logic [CURSOR_W-1:0] total_ff, total_in;
   logic [SW-1:0]       wslot_ff, wslot_in;
   logic [AW-1:0]       wptr_ff, wptr_in;
   logic [CW-1:0]       chan_ff, chan_in;

   // Stage one: the accepted item with a snapshot of the writer position.
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_func_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic [AW-1:0]       s1_waddr_ff;
   logic [CURSOR_W-1:0] s1_cursor_ff;
   logic [FRAMES_IN_W-1:0] s1_frames_ff;
   logic [CURSOR_W-1:0] s1_total_ff;
   logic [SW-1:0]       s1_wslot_ff;

   // Stage two: clamped request, frames available and the adjusted cursor.
   logic                s2_valid_ff, s2_valid_in;
   logic                s2_func_ff;
   logic [SAMPLE_W-1:0] s2_sample_ff;
   logic [AW-1:0]       s2_waddr_ff;
   logic [RW-1:0]       s2_frames_ff, s2_frames_in;
   logic [VW-1:0]       s2_avail_ff, s2_avail_in;
   logic [CURSOR_W-1:0] s2_base_ff, s2_base_in;
   logic [SW-1:0]       s2_wslot_ff;

   logic in_fire, s1_open, s2_open;
   logic [FRAMES_IN_W:0] req_clamped;
   logic [CURSOR_W:0]    lag;
   logic                 behind, jump;
   logic [MW-1:0]        frames_m, avail_m, to_read_m;
   logic [RW-1:0]        to_read;
   logic [VW:0]          slot_diff, slot_fix;
   entry_type            entry;

   assign s2_open  = !s2_valid_ff || push_ready;
   assign s1_open  = !s1_valid_ff || s2_open;
   assign in_ready = accept_en && s1_open;
   assign in_fire  = in_valid && in_ready;

   // Writer position advances as the write transaction is taken.
   always_comb begin
      total_in = total_ff;
      wslot_in = wslot_ff;
      wptr_in  = wptr_ff;
      chan_in  = chan_ff;
      if (in_fire && in_func == KIND_WRITE) begin
         wptr_in = (wptr_ff == LAST_WORD) ? '0 : wptr_ff + AW'(1);
         if (chan_ff == LAST_CH) begin
            chan_in  = '0;
            total_in = total_ff + CURSOR_W'(1);
            if (total_ff == '1) begin
               // The frame count wrapped, so slot and word restart with it.
               wslot_in = '0;
               wptr_in  = '0;
            end else begin
               wslot_in = (wslot_ff == LAST_SLOT) ? '0 : wslot_ff + SW'(1);
            end
         end else begin
            chan_in = chan_ff + CW'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_open) begin
         s1_valid_in = in_fire;
      end
      s2_valid_in = s2_valid_ff;
      if (s2_open) begin
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         wslot_ff    <= '0;
         wptr_ff     <= '0;
         chan_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         total_ff    <= total_in;
         wslot_ff    <= wslot_in;
         wptr_ff     <= wptr_in;
         chan_ff     <= chan_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         s1_func_ff   <= in_func;
         s1_sample_ff <= in_sample;
         s1_waddr_ff  <= wptr_ff;
         s1_cursor_ff <= in_cursor;
         s1_frames_ff <= in_frames;
         s1_total_ff  <= total_ff;
         s1_wslot_ff  <= wslot_ff;
      end
   end

   // Stage one: the request is clamped to 1 to MAX_READ_FRAMES frames, and a cursor
   // more than a full ring behind skips forward to the oldest frame still held.
   always_comb begin
      req_clamped = {1'b0, s1_frames_ff};
      if (req_clamped == '0) begin
         req_clamped = (FRAMES_IN_W + 1)'(1);
      end
      if (req_clamped > MAX_REQ) begin
         req_clamped = MAX_REQ;
      end
      s2_frames_in = req_clamped[RW-1:0];

      lag    = {1'b0, s1_total_ff} - {1'b0, s1_cursor_ff};
      behind = lag[CURSOR_W];
      jump   = !behind && (lag > CAP_WIDE);
      if (behind) begin
         s2_avail_in = '0;
      end else if (jump) begin
         s2_avail_in = CAP_V;
      end else begin
         s2_avail_in = lag[VW-1:0];
      end
      s2_base_in = jump ? (s1_total_ff - CAP_CUR) : s1_cursor_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_open) begin
         s2_func_ff   <= s1_func_ff;
         s2_sample_ff <= s1_sample_ff;
         s2_waddr_ff  <= s1_waddr_ff;
         s2_frames_ff <= s2_frames_in;
         s2_avail_ff  <= s2_avail_in;
         s2_base_ff   <= s2_base_in;
         s2_wslot_ff  <= s1_wslot_ff;
      end
   end

   // Stage two: frames actually read, the returned cursor and the ring slot
   // of the first frame (the writer slot stepped back by the frames held).
   always_comb begin
      frames_m  = MW'(s2_frames_ff);
      avail_m   = MW'(s2_avail_ff);
      to_read_m = (frames_m < avail_m) ? frames_m : avail_m;
      to_read   = to_read_m[RW-1:0];

      slot_diff = (VW + 1)'(s2_wslot_ff) - (VW + 1)'(s2_avail_ff);
      slot_fix  = slot_diff[VW] ? (slot_diff + CAP_VX) : slot_diff;

      entry.kind    = s2_func_ff;
      entry.sample  = s2_sample_ff;
      entry.addr    = (s2_func_ff == KIND_WRITE) ? s2_waddr_ff : AW'(slot_fix[SW-1:0]);
      entry.frames  = s2_frames_ff;
      entry.to_read = to_read;
      entry.cursor  = s2_base_ff + CURSOR_W'(to_read);
   end

   assign push_valid = s2_valid_ff;
   assign push_data  = entry;

endmodule

`default_nettype wire

### src/arosr_queue.sv
// ----------------------------------------------------------------------------
// arosr_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arosr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = arosr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PW:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW:0]      rd_ptr_ff, rd_ptr_in;
   logic             full, empty, push, pop;

   assign full  = (wr_ptr_ff[PW] != rd_ptr_ff[PW]) &&
                  (wr_ptr_ff[PW-1:0] == rd_ptr_ff[PW-1:0]);
   assign empty = (wr_ptr_ff == rd_ptr_ff);

   assign push_ready = !full;
   assign pop_valid  = !empty;
   assign push       = push_valid && !full;
   assign pop        = pop_ready && !empty;
   assign pop_data   = slots_ff[rd_ptr_ff[PW-1:0]];

   assign wr_ptr_in = push ? wr_ptr_ff + (PW + 1)'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + (PW + 1)'(1) : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff[PW-1:0]] <= push_data;
      end
   end

endmodule

`default_nettype wire

### src/arosr_back.sv
// ----------------------------------------------------------------------------
// arosr_back
// Clears the sample store, performs writes and streams out read results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arosr_back #(
   parameter int CAPACITY_FRAMES = arosr_pkg::DEF_CAPACITY_FRAMES,
   parameter int CHANNELS        = arosr_pkg::DEF_CHANNELS,
   parameter int MAX_READ_FRAMES = arosr_pkg::DEF_MAX_READ_FRAMES
) (
   input  logic                            clock,
   input  logic                            reset,
   output logic                            clearing,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  logic [arosr_pkg::entry_w(CAPACITY_FRAMES, CHANNELS, MAX_READ_FRAMES)-1:0]
                                           pop_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [arosr_pkg::SAMPLE_W-1:0]  rsp_sample,
   output logic                            rsp_filler,
   output logic [arosr_pkg::CURSOR_W-1:0]  rsp_cursor,
   output logic                            rsp_last
);
   import arosr_pkg::*;

   localparam int SW    = $clog2(CAPACITY_FRAMES);
   localparam int AW    = $clog2(CAPACITY_FRAMES * CHANNELS);
   localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int RW    = $clog2(MAX_READ_FRAMES + 1);
   localparam int WORDS = CAPACITY_FRAMES * CHANNELS;

   localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY_FRAMES - 1);
   localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
   localparam logic [CW-1:0] LAST_CH   = CW'(CHANNELS - 1);
   localparam logic [AW-1:0] CH_A      = AW'(CHANNELS);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;

   typedef struct packed {
      logic                kind;
      logic [SAMPLE_W-1:0] sample;
      logic [AW-1:0]       addr;
      logic [RW-1:0]       frames;
      logic [RW-1:0]       to_read;
      logic [CURSOR_W-1:0] cursor;
   } entry_type;

   entry_type entry;

   logic [1:0]          state_ff, state_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic [SW-1:0]       slot_ff, slot_in;
   logic [CW-1:0]       ch_ff, ch_in;
   logic [RW-1:0]       frame_ff, frame_in;
   logic [RW-1:0]       frames_ff;
   logic [RW-1:0]       to_read_ff;
   logic [CURSOR_W-1:0] cursor_ff;

   // One result in flight through the RAM read, then the output register.
   logic                p1_valid_ff, p1_valid_in;
   logic                p1_filler_ff;
   logic                p1_last_ff;
   logic [CURSOR_W-1:0] p1_cursor_ff;
   logic                o_valid_ff, o_valid_in;
   logic [SAMPLE_W-1:0] o_sample_ff;
   logic                o_filler_ff;
   logic                o_last_ff;
   logic [CURSOR_W-1:0] o_cursor_ff;

   logic                pop, o_open, p1_open, p1_adv, issue, cur_filler, cur_last;
   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [SAMPLE_W-1:0] wr_data, rd_data;

   assign entry     = pop_data;
   assign clearing  = (state_ff == ST_CLEAR);
   assign pop_ready = (state_ff == ST_IDLE);
   assign pop       = pop_valid && pop_ready;

   assign o_open  = !o_valid_ff || rsp_ready;
   assign p1_adv  = p1_valid_ff && o_open;
   assign p1_open = !p1_valid_ff || o_open;
   assign issue   = (state_ff == ST_READ) && p1_open;

   assign cur_filler = (frame_ff >= to_read_ff);
   assign cur_last   = (frame_ff == frames_ff - RW'(1)) && (ch_ff == LAST_CH);

   assign wr_en   = clearing || (pop && entry.kind == KIND_WRITE);
   assign wr_addr = clearing ? clr_addr_ff : entry.addr;
   assign wr_data = clearing ? '0 : entry.sample;
   assign rd_en   = issue && !cur_filler;
   assign rd_addr = AW'(AW'(slot_ff) * CH_A + AW'(ch_ff));

   arosr_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(WORDS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      slot_in     = slot_ff;
      ch_in       = ch_ff;
      frame_in    = frame_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop && entry.kind == KIND_READ) begin
               slot_in  = entry.addr[SW-1:0];
               ch_in    = '0;
               frame_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (issue) begin
               if (cur_last) begin
                  state_in = ST_IDLE;
               end else if (ch_ff == LAST_CH) begin
                  ch_in    = '0;
                  frame_in = frame_ff + RW'(1);
                  slot_in  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + SW'(1);
               end else begin
                  ch_in = ch_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      p1_valid_in = p1_valid_ff;
      if (issue) begin
         p1_valid_in = 1'b1;
      end else if (p1_adv) begin
         p1_valid_in = 1'b0;
      end
      o_valid_in = o_valid_ff;
      if (p1_adv) begin
         o_valid_in = 1'b1;
      end else if (rsp_ready) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         p1_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         p1_valid_ff <= p1_valid_in;
         o_valid_ff  <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      ch_ff    <= ch_in;
      frame_ff <= frame_in;
      if (pop && entry.kind == KIND_READ) begin
         frames_ff  <= entry.frames;
         to_read_ff <= entry.to_read;
         cursor_ff  <= entry.cursor;
      end
      if (issue) begin
         p1_filler_ff <= cur_filler;
         p1_last_ff   <= cur_last;
         p1_cursor_ff <= cur_last ? cursor_ff : '0;
      end
      if (p1_adv) begin
         o_sample_ff <= p1_filler_ff ? '0 : rd_data;
         o_filler_ff <= p1_filler_ff;
         o_last_ff   <= p1_last_ff;
         o_cursor_ff <= p1_cursor_ff;
      end
   end

   assign rsp_valid  = o_valid_ff;
   assign rsp_sample = o_sample_ff;
   assign rsp_filler = o_filler_ff;
   assign rsp_cursor = o_cursor_ff;
   assign rsp_last   = o_last_ff;

endmodule

`default_nettype wire

### src/audio_ring_overrun_skip_reader_unit.sv
// ----------------------------------------------------------------------------
// audio_ring_overrun_skip_reader_unit
// Ring buffer of interleaved audio frames read through caller-held cursors.
// ----------------------------------------------------------------------------
// A write transaction stores one sample; writes stream at one per cycle while
// the queue has room. A read transaction returns frames * CHANNELS results at
// one per cycle while rsp_tready is high, with the advanced cursor on the one
// marked tlast; the front part classifies it in its stage one and stage two
// registers, the back part then starts it, and the back part serves one read
// at a time, taking no new item until that read's last result is issued.
// A cursor more than CAPACITY_FRAMES behind the writer jumps to the oldest
// frame held. After reset the sample RAM is cleared one word per cycle, all
// CAPACITY_FRAMES * CHANNELS words (2048 by default), with req_tready low.
`timescale 1ns / 1ps
`default_nettype none

module audio_ring_overrun_skip_reader_unit #(
   parameter int CAPACITY_FRAMES = arosr_pkg::DEF_CAPACITY_FRAMES,
   parameter int CHANNELS        = arosr_pkg::DEF_CHANNELS,
   parameter int MAX_READ_FRAMES = arosr_pkg::DEF_MAX_READ_FRAMES
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: sample[31:0], cursor[79:32], read_frames[85:80], zero[87:86]
   input  logic [arosr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: func[0]
   input  logic                              req_tuser,
   // Result channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: sample_out[31:0], new_cursor[79:32]
   output logic [arosr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: is_filler[0]
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import arosr_pkg::*;

   localparam int ENTRY_W = entry_w(CAPACITY_FRAMES, CHANNELS, MAX_READ_FRAMES);

   logic                clearing;
   logic                push_valid, push_ready, pop_valid, pop_ready;
   logic [ENTRY_W-1:0]  push_data, pop_data;
   logic [SAMPLE_W-1:0] rsp_sample;
   logic [CURSOR_W-1:0] rsp_cursor;

   arosr_front #(
      .CAPACITY_FRAMES(CAPACITY_FRAMES),
      .CHANNELS       (CHANNELS),
      .MAX_READ_FRAMES(MAX_READ_FRAMES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept_en (!clearing),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_func   (req_tuser),
      .in_sample (req_tdata[SAMPLE_W-1:0]),
      .in_cursor (req_tdata[SAMPLE_W +: CURSOR_W]),
      .in_frames (req_tdata[SAMPLE_W + CURSOR_W +: FRAMES_IN_W]),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data)
   );

   arosr_queue #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data)
   );

   arosr_back #(
      .CAPACITY_FRAMES(CAPACITY_FRAMES),
      .CHANNELS       (CHANNELS),
      .MAX_READ_FRAMES(MAX_READ_FRAMES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .clearing  (clearing),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_sample(rsp_sample),
      .rsp_filler(rsp_tuser),
      .rsp_cursor(rsp_cursor),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {rsp_cursor, rsp_sample};

endmodule

`default_nettype wire

### src/arosr_checker.sv
// ----------------------------------------------------------------------------
// arosr_checker
// Port-level checks of the audio ring reader, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "audio_ring_overrun_skip_reader_unit_macros.svh"

module arosr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [arosr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tlast
);

   // Right after reset the store is being cleared and nothing is pending.
   `AROSR_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !req_tready && !rsp_tvalid, "request or result active right after reset")

   `AROSR_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result transaction changed")

   // Padding past the available frames always carries a zero sample.
   `AROSR_ASSERT(a_filler_zero, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata[31:0] == 32'd0, "filler result with nonzero sample")

   // Only the closing result of a read reports the advanced cursor.
   `AROSR_ASSERT(a_cursor_on_last, clock, reset, rsp_tvalid && !rsp_tlast |-> rsp_tdata[79:32] == 48'd0, "cursor reported before the last result")

endmodule

bind audio_ring_overrun_skip_reader_unit arosr_checker u_checker (.*);

`default_nettype wire
